// ----- src/msep_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msep_pkg
// Shared types and constants for the music score event parser.
// ----------------------------------------------------------------------------
package msep_pkg;

   localparam int CHANNELS_DEF = 16;

   localparam int KIND_W   = 3;
   localparam int CHAN_W   = 4;
   localparam int ARG_W    = 8;
   localparam int DELAY_W  = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   localparam int SRATE_W = 17;
   localparam int TRATE_W = 10;
   localparam int TICKS_W = 32;
   localparam int VEL_W   = 7;
   localparam int PROD_W  = 33;

   localparam logic [SRATE_W-1:0] SRATE_RST = 17'd48000;
   localparam logic [TRATE_W-1:0] TRATE_RST = 10'd140;
   localparam logic [VEL_W-1:0]   VEL_RST   = 7'd127;
   localparam logic [TICKS_W-1:0] TICKS_OVF = 32'h00ff_ffff;
   localparam logic [TICKS_W-1:0] TICKS_MAX = 32'd40000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE   = 2'd2;

   // event type field of a descriptor, bits 6:4
   localparam logic [2:0] ET_OFF  = 3'd0;
   localparam logic [2:0] ET_ON   = 3'd1;
   localparam logic [2:0] ET_PIT  = 3'd2;
   localparam logic [2:0] ET_SYS  = 3'd3;
   localparam logic [2:0] ET_CTRL = 3'd4;
   localparam logic [2:0] ET_END  = 3'd6;

   typedef enum logic [3:0] {
      PH_DESC,
      PH_OFF_NOTE,
      PH_ON_NOTE,
      PH_ON_VEL,
      PH_PITCH,
      PH_SYS,
      PH_CTRL_NUM,
      PH_CTRL_VAL,
      PH_DELAY
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      K_OFF,
      K_ON,
      K_PITCH,
      K_SYS,
      K_CTRL,
      K_END,
      K_DELAY,
      K_ERR
   } kind_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_MUL,
      SQ_DIV,
      SQ_OUT0,
      SQ_OUT1
   } seq_type;

endpackage

// ----- src/msep_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msep_if
// Valid/ready channels of the score event parser: byte input, event output
// and register write port.
// ----------------------------------------------------------------------------
interface msep_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] score_byte;
   logic       last_byte;

   modport source (output valid, action, score_byte, last_byte, input ready);
   modport sink   (input valid, action, score_byte, last_byte, output ready);
endinterface

interface msep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [3:0]  event_channel;
   logic [7:0]  first_arg;
   logic [7:0]  second_arg;
   logic [31:0] delay_samples;
   logic        last_of_run;

   modport source (output valid, event_kind, event_channel, first_arg, second_arg,
                   delay_samples, last_of_run, input ready);
   modport sink   (input valid, event_kind, event_channel, first_arg, second_arg,
                   delay_samples, last_of_run, output ready);
endinterface

interface msep_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [16:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/music_score_event_parser.sv -----
`timescale 1ns / 1ps
// Timing: an event word appears the cycle after its byte is taken; a byte that
//   closes a delay passes the multiply state and then the bit-serial restoring
//   divider before its word appears.
// Flow: a new byte is taken only while the sequencer is idle, once the words of
//   the last byte have been accepted; a byte with no word leaves it idle.
// Reset: synchronous; parser stopped, velocities 127, registers at defaults.
// ----------------------------------------------------------------------------
// music_score_event_parser
// Decodes score body bytes into note, pitch, system, controller, delay, end and error events.
// ----------------------------------------------------------------------------
module music_score_event_parser #(
   parameter int CHANNELS = msep_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   msep_req_if.sink    req_ch,
   msep_rsp_if.source  rsp_ch,
   msep_csr_if.sink    csr_ch
);
   import msep_pkg::*;

   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // configuration
   logic               loop_en_ff;
   logic [SRATE_W-1:0] srate_ff;
   logic [TRATE_W-1:0] trate_ff;

   // parse state
   phase_type          phase_ff, phase_in;
   logic               playing_ff, playing_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic               gfinal_ff, gfinal_in;
   logic [ARG_W-1:0]   pend_ff, pend_in;
   logic [VEL_W-1:0]   vel_ff [CHANNELS];
   logic [VEL_W-1:0]   vel_in [CHANNELS];
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [TRATE_W-1:0] trem_ff, trem_in;

   // sequencer and result word
   seq_type            seq_ff, seq_in;
   kind_type           rkind_ff, rkind_in;
   logic [CHAN_W-1:0]  rchan_ff, rchan_in;
   logic [ARG_W-1:0]   ra_ff, ra_in;
   logic [ARG_W-1:0]   rb_ff, rb_in;
   logic               has1_ff, has1_in;

   // divider
   logic [PROD_W-1:0]  qd_ff, qd_in;
   logic [TRATE_W-1:0] drem_ff, drem_in;
   logic [TRATE_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // item decode results
   logic               take;
   logic               p_has0, p_has1, p_mul, p_fail, p_end, p_fresh, p_vwr;
   logic [VEL_W-1:0]   vel_rd;
   logic [7:0]         v;
   logic [TICKS_W-1:0] tacc;
   logic [TRATE_W:0]   dtry;
   logic [PROD_W-1:0]  prod;

   assign take         = req_ch.valid && req_ch.ready;
   assign v            = req_ch.score_byte;
   assign req_ch.ready = (seq_ff == SQ_IDLE);
   assign csr_ch.ready = 1'b1;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_en_ff <= 1'b0;
         srate_ff   <= SRATE_RST;
         trate_ff   <= TRATE_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_LOOP_ENABLE: loop_en_ff <= csr_ch.data[0];
            CSR_SAMPLE_RATE: srate_ff   <= csr_ch.data[SRATE_W-1:0];
            CSR_TICK_RATE:   trate_ff   <= csr_ch.data[TRATE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- velocity read ----------------
   always_comb begin
      vel_rd = VEL_RST;
      for (int i = 0; i < CHANNELS; i++) begin
         if (chan_ff == CHAN_W'(i)) vel_rd = vel_ff[i];
      end
   end

   assign tacc = {ticks_ff[TICKS_W-8:0], v[6:0]};

   // ---------------- byte decode ----------------
   always_comb begin
      phase_in   = phase_ff;
      playing_in = playing_ff;
      chan_in    = chan_ff;
      gfinal_in  = gfinal_ff;
      pend_in    = pend_ff;
      ticks_in   = ticks_ff;
      p_has0     = 1'b0;
      p_mul      = 1'b0;
      p_fail     = 1'b0;
      p_end      = 1'b0;
      p_fresh    = 1'b0;
      p_vwr      = 1'b0;
      rkind_in   = K_ERR;
      rchan_in   = '0;
      ra_in      = '0;
      rb_in      = '0;

      if (req_ch.action) begin
         p_fresh    = 1'b1;
         playing_in = 1'b1;
      end else if (playing_ff) begin
         case (phase_ff)
            PH_DESC: begin
               chan_in   = v[3:0];
               gfinal_in = v[7];
               case (v[6:4])
                  ET_OFF:  phase_in = PH_OFF_NOTE;
                  ET_ON:   phase_in = PH_ON_NOTE;
                  ET_PIT:  phase_in = PH_PITCH;
                  ET_SYS:  phase_in = PH_SYS;
                  ET_CTRL: phase_in = PH_CTRL_NUM;
                  ET_END: begin
                     p_end    = 1'b1;
                     p_has0   = 1'b1;
                     rkind_in = K_END;
                     rchan_in = v[3:0];
                     if (loop_en_ff) p_fresh = 1'b1;
                     else playing_in = 1'b0;
                  end
                  default: p_fail = 1'b1;
               endcase
            end
            PH_OFF_NOTE: begin
               p_has0   = 1'b1;
               rkind_in = K_OFF;
               rchan_in = chan_ff;
               ra_in    = {1'b0, v[6:0]};
            end
            PH_ON_NOTE: begin
               pend_in = {1'b0, v[6:0]};
               if (v[7]) begin
                  phase_in = PH_ON_VEL;
               end else begin
                  p_has0   = 1'b1;
                  rkind_in = K_ON;
                  rchan_in = chan_ff;
                  ra_in    = {1'b0, v[6:0]};
                  rb_in    = {1'b0, vel_rd};
               end
            end
            PH_ON_VEL: begin
               p_vwr    = 1'b1;
               p_has0   = 1'b1;
               rkind_in = K_ON;
               rchan_in = chan_ff;
               ra_in    = pend_ff;
               // channels beyond the table read back the default
               rb_in    = (32'(chan_ff) < CHANNELS) ? {1'b0, v[6:0]} : {1'b0, VEL_RST};
            end
            PH_PITCH, PH_SYS: begin
               p_has0   = 1'b1;
               rkind_in = (phase_ff == PH_PITCH) ? K_PITCH : K_SYS;
               rchan_in = chan_ff;
               ra_in    = v;
            end
            PH_CTRL_NUM: begin
               pend_in  = v;
               phase_in = PH_CTRL_VAL;
            end
            PH_CTRL_VAL: begin
               p_has0   = 1'b1;
               rkind_in = K_CTRL;
               rchan_in = chan_ff;
               ra_in    = pend_ff;
               rb_in    = v;
            end
            PH_DELAY: begin
               if (ticks_ff > TICKS_OVF) begin
                  p_fail = 1'b1;
               end else begin
                  ticks_in = tacc;
                  if (!v[7]) begin
                     if (tacc > TICKS_MAX) begin
                        p_fail = 1'b1;
                     end else begin
                        p_mul    = 1'b1;
                        p_has0   = 1'b1;
                        rkind_in = K_DELAY;
                        phase_in = PH_DESC;
                     end
                  end
               end
            end
            default: p_fail = 1'b1;
         endcase

         // an event just finished: a delay follows the last of a group
         if (p_has0 && (phase_ff != PH_DESC) && (phase_ff != PH_DELAY)) begin
            if (gfinal_ff) begin
               phase_in = PH_DELAY;
               ticks_in = '0;
            end else begin
               phase_in = PH_DESC;
            end
         end

         if (p_fail) begin
            p_has0     = 1'b1;
            rkind_in   = K_ERR;
            rchan_in   = '0;
            ra_in      = '0;
            rb_in      = '0;
            playing_in = 1'b0;
         end
      end

      if (p_fresh) begin
         phase_in  = PH_DESC;
         chan_in   = '0;
         gfinal_in = 1'b0;
         pend_in   = '0;
         ticks_in  = '0;
      end

      // premature end of score
      p_has1 = !req_ch.action && playing_ff && req_ch.last_byte && playing_in && !p_end;
      if (p_has1) playing_in = 1'b0;
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         if (p_fresh) vel_in[i] = VEL_RST;
         else if (p_vwr && chan_ff == CHAN_W'(i)) vel_in[i] = v[6:0];
         else vel_in[i] = vel_ff[i];
      end
   end

   // ---------------- sequencer ----------------
   assign prod = PROD_W'(ticks_ff[15:0]) * PROD_W'(srate_ff) + PROD_W'(trem_ff);
   assign dtry = {drem_ff, qd_ff[PROD_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      seq_in  = seq_ff;
      has1_in = has1_ff;
      qd_in   = qd_ff;
      drem_in = drem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      trem_in = trem_ff;

      case (seq_ff)
         SQ_IDLE: begin
            if (take) begin
               has1_in = p_has1;
               if (p_fresh) trem_in = '0;
               if (p_mul) seq_in = SQ_MUL;
               else if (p_has0) seq_in = SQ_OUT0;
               else if (p_has1) seq_in = SQ_OUT1;
            end
         end
         SQ_MUL: begin
            qd_in   = prod;
            drem_in = '0;
            dvs_in  = (trate_ff == '0) ? TRATE_W'(1) : trate_ff;
            cnt_in  = '0;
            seq_in  = SQ_DIV;
         end
         SQ_DIV: begin
            // restoring step, one quotient bit per cycle
            if (!dtry[TRATE_W]) begin
               drem_in = dtry[TRATE_W-1:0];
               qd_in   = {qd_ff[PROD_W-2:0], 1'b1};
            end else begin
               drem_in = {drem_ff[TRATE_W-2:0], qd_ff[PROD_W-1]};
               qd_in   = {qd_ff[PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               trem_in = drem_in;
               seq_in  = SQ_OUT0;
            end
         end
         SQ_OUT0: begin
            if (rsp_ch.ready) seq_in = has1_ff ? SQ_OUT1 : SQ_IDLE;
         end
         SQ_OUT1: begin
            if (rsp_ch.ready) seq_in = SQ_IDLE;
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= SQ_IDLE;
         phase_ff   <= PH_DESC;
         playing_ff <= 1'b0;
         chan_ff    <= '0;
         gfinal_ff  <= 1'b0;
         pend_ff    <= '0;
         ticks_ff   <= '0;
         trem_ff    <= '0;
         has1_ff    <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) vel_ff[i] <= VEL_RST;
      end else begin
         seq_ff  <= seq_in;
         trem_ff <= trem_in;
         has1_ff <= has1_in;
         if (take) begin
            phase_ff   <= phase_in;
            playing_ff <= playing_in;
            chan_ff    <= chan_in;
            gfinal_ff  <= gfinal_in;
            pend_ff    <= pend_in;
            ticks_ff   <= ticks_in;
            for (int i = 0; i < CHANNELS; i++) vel_ff[i] <= vel_in[i];
         end else if (seq_ff == SQ_MUL) begin
            ticks_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      qd_ff   <= qd_in;
      drem_ff <= drem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (take) begin
         rkind_ff <= rkind_in;
         rchan_ff <= rchan_in;
         ra_ff    <= ra_in;
         rb_ff    <= rb_in;
      end
   end

   // ---------------- result word ----------------
   always_comb begin
      rsp_ch.valid         = (seq_ff == SQ_OUT0) || (seq_ff == SQ_OUT1);
      rsp_ch.event_kind    = rkind_ff;
      rsp_ch.event_channel = rchan_ff;
      rsp_ch.first_arg     = ra_ff;
      rsp_ch.second_arg    = rb_ff;
      rsp_ch.delay_samples = '0;
      rsp_ch.last_of_run   = !has1_ff;
      if (seq_ff == SQ_OUT1) begin
         rsp_ch.event_kind    = K_ERR;
         rsp_ch.event_channel = '0;
         rsp_ch.first_arg     = '0;
         rsp_ch.second_arg    = '0;
         rsp_ch.last_of_run   = 1'b1;
      end else if (rkind_ff == K_DELAY) begin
         // counts past 32 bits saturate
         rsp_ch.delay_samples = qd_ff[PROD_W-1] ? '1 : qd_ff[DELAY_W-1:0];
      end
   end

endmodule
